>>> rtl/bced_pkg.sv
// Package for the button click event detector.
// Payload structs, register codes and reset values; no dependencies.
package bced_pkg;

  localparam int unsigned TICK_W = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [TICK_W-1:0] AGE_MAX = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 1'b1;

  localparam logic [TICK_W-1:0] DEBOUNCE_RST = 16'd200;
  localparam logic [TICK_W-1:0] WINDOW_RST   = 16'd1000;

  typedef struct packed {
    logic button_down;
    logic ack_press;
  } in_item_t;

  typedef struct packed {
    logic              is_pressed;
    logic              press_event;
    logic              release_event;
    logic              multi_click_event;
    logic              was_pressed;
    logic [TICK_W-1:0] press_count;
    logic [TICK_W-1:0] click_count;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [TICK_W-1:0]    data;
  } cfg_wr_t;

  typedef struct packed {
    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] click_window_ticks;
  } cfg_t;

endpackage

>>> rtl/bced_ifs.sv
// Valid/ready channel interfaces for the button click event detector.
// Depends on bced_pkg for the payload types.
interface bced_in_if;
  logic               valid;
  logic               ready;
  bced_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bced_out_if;
  logic                valid;
  logic                ready;
  bced_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bced_cfg_if;
  logic              valid;
  logic              ready;
  bced_pkg::cfg_wr_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/bced_cfg.sv
// Configuration register file for the button click event detector.
// Depends on bced_pkg and bced_ifs.
module bced_cfg (
  input  logic           clk,
  input  logic           rst,
  bced_cfg_if.sink       cfg_ch,
  output bced_pkg::cfg_t cfg
);
  import bced_pkg::*;

  cfg_t regs;

  assign cfg_ch.ready = 1'b1;
  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_ticks     <= DEBOUNCE_RST;
      regs.click_window_ticks <= WINDOW_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.payload.index)
        CFG_DEBOUNCE: regs.debounce_ticks     <= cfg_ch.payload.data;
        CFG_WINDOW:   regs.click_window_ticks <= cfg_ch.payload.data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/button_click_event_detector_top.sv
// Top level of the button click event detector: tick state machine and result register.
// Depends on bced_pkg, bced_ifs and bced_cfg.
//
//   channel  | dir  | transaction
//   ---------+------+---------------------------------------------------
//   in_ch    | sink | one 1 ms tick: button_down, ack_press
//   out_ch   | src  | one result per tick: events, flag, press/click counts
//   cfg_ch   | sink | register write: index 0 debounce, 1 click window
//
// For each tick, the next state and the result are formed in a single
// combinational pass from the state registers and land in the result register
// on the accepting edge. A new tick is taken every cycle while the result
// register is empty or being emptied. A stalled output holds its result and
// back-pressures the input. Reset (synchronous) clears the state, the
// counters and the result valid, and restores the register defaults.
module button_click_event_detector_top (
  input logic        clk,
  input logic        rst,
  bced_in_if.sink    in_ch,
  bced_out_if.source out_ch,
  bced_cfg_if.sink   cfg_ch
);
  import bced_pkg::*;

  cfg_t cfg;

  bced_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // State
  logic              waiting_release;
  logic [TICK_W-1:0] release_age;
  logic [TICK_W-1:0] click_age;
  logic [TICK_W-1:0] presses;
  logic [TICK_W-1:0] clicks;
  logic              press_flag;

  logic              waiting_release_next;
  logic [TICK_W-1:0] release_age_next;
  logic [TICK_W-1:0] click_age_next;
  logic [TICK_W-1:0] presses_next;
  logic [TICK_W-1:0] clicks_next;
  logic              press_flag_next;

  // Result register
  logic      out_valid;
  out_item_t out_item;
  out_item_t out_item_next;

  logic accept;

  // Aged timers and the window-cleared click count
  logic [TICK_W-1:0] release_aged;
  logic [TICK_W-1:0] click_aged;
  logic [TICK_W-1:0] clicks_kept;
  logic [TICK_W-1:0] clicks_inc;
  logic              flag_set;

  assign in_ch.ready    = !out_valid || out_ch.ready;
  assign accept         = in_ch.valid && in_ch.ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;

  always_comb begin
    release_aged = (release_age == AGE_MAX) ? AGE_MAX : release_age + 1'b1;
    click_aged   = (click_age == AGE_MAX) ? AGE_MAX : click_age + 1'b1;
    // window expiry only counts while waiting for a press
    clicks_kept  = (clicks != '0 && click_aged >= cfg.click_window_ticks) ? '0 : clicks;
    clicks_inc   = clicks_kept + 1'b1;

    waiting_release_next = waiting_release;
    release_age_next     = release_aged;
    click_age_next       = click_aged;
    presses_next         = presses;
    clicks_next          = clicks;
    flag_set             = press_flag;
    out_item_next        = '0;

    if (!waiting_release) begin
      clicks_next = clicks_kept;
      if (in_ch.payload.button_down) begin
        release_age_next                = '0;
        flag_set                        = 1'b1;
        if (clicks_kept == '0) begin
          click_age_next = '0;
        end
        presses_next                    = presses + 1'b1;
        clicks_next                     = clicks_inc;
        out_item_next.press_event       = 1'b1;
        out_item_next.multi_click_event = (clicks_inc >= TICK_W'(2));
        waiting_release_next            = 1'b1;
      end
    end else begin
      if (in_ch.payload.button_down) begin
        release_age_next = '0;
      end
      // a zero debounce releases on the first tick after the press
      if (release_age_next >= cfg.debounce_ticks) begin
        out_item_next.release_event = 1'b1;
        waiting_release_next        = 1'b0;
      end
    end

    out_item_next.is_pressed  = waiting_release_next;
    out_item_next.was_pressed = flag_set;
    out_item_next.press_count = presses_next;
    out_item_next.click_count = clicks_next;
    // acknowledge clears the flag only after it has been reported
    press_flag_next = flag_set && !in_ch.payload.ack_press;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting_release <= 1'b0;
      release_age     <= '0;
      click_age       <= '0;
      presses         <= '0;
      clicks          <= '0;
      press_flag      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        waiting_release <= waiting_release_next;
        release_age     <= release_age_next;
        click_age       <= click_age_next;
        presses         <= presses_next;
        clicks          <= clicks_next;
        press_flag      <= press_flag_next;
        out_valid       <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= out_item_next;
    end
  end

endmodule
